// ===== hw/rtl/assert_macros.svh =====
// assertion helper macros for the event trigger unit
// expects i_clk and i_rst_n in the scope where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked only out of reset
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked only out of reset
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/etpu_pkg.sv =====
// shared types and constants for the event trigger and pulse height unit
// no dependencies; imported by every module of the block
`default_nettype none

package etpu_pkg;

    localparam int NUM_CH    = 4;
    localparam int CH_W      = 2;
    localparam int SAMPLE_W  = 16;
    localparam int HGT_W     = 16;
    localparam int CNT_W     = 3;
    localparam int SUM_W     = 32;
    localparam int EVC_W     = 16;

    localparam logic signed [SAMPLE_W-1:0] THR_RESET = 16'sd100;
    localparam logic [CNT_W-1:0]           MIN_C_RESET = 3'd1;
    localparam logic signed [SAMPLE_W-1:0] START_MAX = -16'sd8100;
    localparam logic signed [SAMPLE_W-1:0] START_MIN = 16'sd8100;

    // configuration port
    localparam int CFG_AW = 3;
    localparam int CFG_DW = 16;
    localparam logic [CFG_AW-1:0] REG_THR0      = 3'd0;
    localparam logic [CFG_AW-1:0] REG_THR3      = 3'd3;
    localparam logic [CFG_AW-1:0] REG_MIN_COINC = 3'd4;

    // input word modes
    typedef enum logic [1:0] {
        MODE_SAMPLE = 2'd0,
        MODE_EOE    = 2'd1,
        MODE_TICK   = 2'd2
    } t_mode;

    localparam logic KIND_VERDICT = 1'b0;
    localparam logic KIND_REPORT  = 1'b1;

    // stream widths
    localparam int IN_TUSER_W  = 4;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 64;

    // output tdata field offsets
    localparam int OFF_MASK  = 0;
    localparam int OFF_COUNT = OFF_MASK + NUM_CH;
    localparam int OFF_ACC   = OFF_COUNT + CNT_W;
    localparam int OFF_RCH   = OFF_ACC + 1;
    localparam int OFF_SUM   = OFF_RCH + CH_W;
    localparam int OFF_EVC   = OFF_SUM + SUM_W;
    localparam int OUT_USED  = OFF_EVC + EVC_W;

    // command queue
    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;

    typedef struct packed {
        logic                           tick;
        logic [NUM_CH-1:0]              mask;
        logic [CNT_W-1:0]               count;
        logic                           accept;
        logic [NUM_CH-1:0]              hvalid;
        logic [NUM_CH-1:0][HGT_W-1:0]   height;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

`default_nettype wire

// ===== hw/rtl/event_trigger_and_pulse_height_unit.sv =====
// Event trigger and pulse height unit, four ADC channels.
// Input stream: s_axis tuser {mode, channel}, tdata {sample}. Mode sample
// updates the channel's running max/min and trigger bit and gives no output;
// end of event gives one verdict word (tlast set) and rearms; a report tick
// gives one height report word per channel, channel 0 first, tlast on the
// last one, and clears the sums and counts.
// Output stream: m_axis, tuser = kind (0 verdict, 1 report).
// Path: a taken input word writes its command into the queue, and the back end
// then loads it from the queue head into the output register.
// Throughput: one input word per cycle while the queue is not full; a verdict
// gives one output word and a tick four, all through the single output register.
// A four-deep command queue between the input side and the output side
// lets input words keep flowing while the receiver stalls; tready drops only
// when the queue is full. Samples never enter the queue.
// Reset (i_rst_n low, synchronous): thresholds 100, coincidence 1, per-event
// state rearmed, sums and counts zero, queue and output emptied.
// Configuration: i_cfg_we with i_cfg_addr 0..3 threshold, 4 coincidence,
// to be written by the user only while the block is idle; the block does not enforce it.
`default_nettype none
`include "assert_macros.svh"

module event_trigger_and_pulse_height_unit import etpu_pkg::*; (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_cfg_we,
    input  wire logic [CFG_AW-1:0]        i_cfg_addr,
    input  wire logic [CFG_DW-1:0]        i_cfg_data,
    input  wire logic                     s_axis_tvalid,
    output logic                          s_axis_tready,
    input  wire logic [IN_TDATA_W-1:0]    s_axis_tdata,   // sample[15:0]
    input  wire logic [IN_TUSER_W-1:0]    s_axis_tuser,   // mode[1:0], channel[3:2]
    output logic                          m_axis_tvalid,
    input  wire logic                     m_axis_tready,
    // trigger_mask[3:0], trigger_count[6:4], accept[7], report_channel[9:8],
    // height_sum[41:10], event_count[57:42], zero[63:58]
    output logic [OUT_TDATA_W-1:0]        m_axis_tdata,
    output logic [0:0]                    m_axis_tuser,   // kind[0]
    output logic                          m_axis_tlast
);

    logic    w_push;
    logic    w_pop;
    t_cmd    w_cmd_in;
    t_cmd    w_cmd_out;
    t_q_stat w_q_stat;

    etpu_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_mode     (s_axis_tuser[1:0]),
        .i_channel  (s_axis_tuser[3:2]),
        .i_sample   (s_axis_tdata),
        .i_q_stat   (w_q_stat),
        .o_push     (w_push),
        .o_cmd      (w_cmd_in)
    );

    etpu_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_cmd_in),
        .i_pop   (w_pop),
        .o_cmd   (w_cmd_out),
        .o_stat  (w_q_stat)
    );

    etpu_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (w_cmd_out),
        .i_q_stat  (w_q_stat),
        .o_pop     (w_pop),
        .i_m_ready (m_axis_tready),
        .o_m_valid (m_axis_tvalid),
        .o_m_data  (m_axis_tdata),
        .o_m_kind  (m_axis_tuser[0]),
        .o_m_last  (m_axis_tlast)
    );

    `ASSERT_IMPLIES(a_queue_no_overflow, w_push, !w_q_stat.full, "command pushed into full queue")
    `ASSERT_IMPLIES(a_queue_no_underflow, w_pop, !w_q_stat.empty, "command popped from empty queue")
    `ASSERT_IMPLIES(a_verdict_word,
        m_axis_tvalid && (m_axis_tuser[0] == KIND_VERDICT),
        m_axis_tlast && (m_axis_tdata[OFF_COUNT +: CNT_W] ==
            CNT_W'($countones(m_axis_tdata[OFF_MASK +: NUM_CH]))),
        "verdict word inconsistent")
    `ASSERT_IMPLIES(a_report_last,
        m_axis_tvalid && (m_axis_tuser[0] == KIND_REPORT) && m_axis_tlast,
        m_axis_tdata[OFF_RCH +: CH_W] == CH_W'(NUM_CH - 1),
        "report burst ended early")

endmodule

`default_nettype wire

// ===== hw/rtl/etpu_front.sv =====
// front end: takes input words, tracks per-channel extremes and trigger bits,
// and turns end-of-event and tick words into queue commands; uses etpu_pkg
`default_nettype none

module etpu_front import etpu_pkg::*; (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire logic [CFG_AW-1:0]          i_cfg_addr,
    input  wire logic [CFG_DW-1:0]          i_cfg_data,
    input  wire logic                       i_valid,
    output logic                            o_ready,
    input  wire logic [1:0]                 i_mode,
    input  wire logic [CH_W-1:0]            i_channel,
    input  wire logic signed [SAMPLE_W-1:0] i_sample,
    input  wire t_q_stat                    i_q_stat,
    output logic                            o_push,
    output t_cmd                            o_cmd
);

    logic signed [SAMPLE_W-1:0] r_thr [NUM_CH];
    logic [CNT_W-1:0]           r_min_c;
    logic signed [SAMPLE_W-1:0] r_max [NUM_CH];
    logic signed [SAMPLE_W-1:0] r_min [NUM_CH];
    logic [NUM_CH-1:0]          r_trig;

    logic                       w_acc;
    logic signed [SAMPLE_W:0]   w_neg;
    logic signed [SAMPLE_W:0]   w_thr_x;
    logic                       w_hit;
    logic [CH_W-1:0]            w_bit;
    logic [CNT_W-1:0]           w_count;

    assign o_ready = !i_q_stat.full;
    assign w_acc   = i_valid && o_ready;

    // 17-bit compare so that negating -32768 does not wrap
    assign w_neg   = -{i_sample[SAMPLE_W-1], i_sample};
    assign w_thr_x = {r_thr[i_channel][SAMPLE_W-1], r_thr[i_channel]};
    assign w_hit   = w_neg > w_thr_x;
    // channel 0 sits in the top mask bit
    assign w_bit   = CH_W'(NUM_CH - 1) - i_channel;
    assign w_count = CNT_W'($countones(r_trig));

    always_comb begin
        o_cmd.tick   = (i_mode == MODE_TICK);
        o_cmd.mask   = r_trig;
        o_cmd.count  = w_count;
        o_cmd.accept = (w_count >= r_min_c);
        for (int i = 0; i < NUM_CH; i++) begin
            o_cmd.hvalid[i] = r_max[i] > r_min[i];
            o_cmd.height[i] = HGT_W'(r_max[i] - r_min[i]);
        end
    end

    assign o_push = w_acc && ((i_mode == MODE_EOE) || (i_mode == MODE_TICK));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_CH; i++) begin
                r_thr[i] <= THR_RESET;
                r_max[i] <= START_MAX;
                r_min[i] <= START_MIN;
            end
            r_min_c <= MIN_C_RESET;
            r_trig  <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr) inside
                    [REG_THR0:REG_THR3]: r_thr[i_cfg_addr[CH_W-1:0]] <= i_cfg_data;
                    REG_MIN_COINC:       r_min_c <= i_cfg_data[CNT_W-1:0];
                    default: ;
                endcase
            end
            if (w_acc) begin
                case (i_mode)
                    MODE_SAMPLE: begin
                        if (i_sample > r_max[i_channel]) r_max[i_channel] <= i_sample;
                        if (i_sample < r_min[i_channel]) r_min[i_channel] <= i_sample;
                        if (w_hit) r_trig[w_bit] <= 1'b1;
                    end
                    MODE_EOE: begin
                        // rearm for the next event
                        for (int i = 0; i < NUM_CH; i++) begin
                            r_max[i] <= START_MAX;
                            r_min[i] <= START_MIN;
                        end
                        r_trig <= '0;
                    end
                    default: ;
                endcase
            end
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/etpu_queue.sv =====
// short command queue between front and back end
// register based, fall-through head; uses etpu_pkg
`default_nettype none

module etpu_queue import etpu_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  wire t_cmd   i_cmd,
    input  wire logic   i_pop,
    output t_cmd        o_cmd,
    output t_q_stat     o_stat
);

    t_cmd              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QCNT_W-1:0] r_cnt;

    assign o_cmd        = r_mem[r_rd];
    assign o_stat.full  = (r_cnt == QCNT_W'(QDEPTH));
    assign o_stat.empty = (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + 1'b1;
            if (i_pop)  r_rd <= r_rd + 1'b1;
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_cmd;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/etpu_back.sv =====
// back end: runs queue commands, keeps per-channel height sums and event
// counts, and drives the registered output word; uses etpu_pkg
`default_nettype none

module etpu_back import etpu_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_cmd               i_cmd,
    input  wire t_q_stat            i_q_stat,
    output logic                    o_pop,
    input  wire logic               i_m_ready,
    output logic                    o_m_valid,
    output logic [OUT_TDATA_W-1:0]  o_m_data,
    output logic                    o_m_kind,
    output logic                    o_m_last
);

    logic [SUM_W-1:0]   r_total [NUM_CH];
    logic [EVC_W-1:0]   r_evcnt [NUM_CH];
    logic [CH_W-1:0]    r_idx;
    logic               r_m_valid;

    logic               r_kind;
    logic               r_last;
    logic [NUM_CH-1:0]  r_mask;
    logic [CNT_W-1:0]   r_count;
    logic               r_accept;
    logic [CH_W-1:0]    r_rch;
    logic [SUM_W-1:0]   r_sum;
    logic [EVC_W-1:0]   r_evc;

    logic               w_go;
    logic               w_idx_end;
    logic [SUM_W-1:0]   n_total [NUM_CH];
    logic [EVC_W-1:0]   n_evcnt [NUM_CH];

    assign w_go      = (!r_m_valid || i_m_ready) && !i_q_stat.empty;
    assign w_idx_end = (r_idx == CH_W'(NUM_CH - 1));
    assign o_pop     = w_go && (!i_cmd.tick || w_idx_end);

    // saturating accumulate for every channel
    always_comb begin
        for (int i = 0; i < NUM_CH; i++) begin
            logic [SUM_W:0] sum;
            sum = {1'b0, r_total[i]} + (SUM_W+1)'(i_cmd.height[i]);
            n_total[i] = sum[SUM_W] ? '1 : sum[SUM_W-1:0];
            n_evcnt[i] = (r_evcnt[i] == '1) ? r_evcnt[i] : r_evcnt[i] + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_CH; i++) begin
                r_total[i] <= '0;
                r_evcnt[i] <= '0;
            end
            r_idx     <= '0;
            r_m_valid <= 1'b0;
        end else if (w_go) begin
            r_m_valid <= 1'b1;
            if (!i_cmd.tick) begin
                for (int i = 0; i < NUM_CH; i++) begin
                    if (i_cmd.hvalid[i]) begin
                        r_total[i] <= n_total[i];
                        r_evcnt[i] <= n_evcnt[i];
                    end
                end
            end else begin
                // one channel report per word, cleared as it goes out
                r_total[r_idx] <= '0;
                r_evcnt[r_idx] <= '0;
                r_idx <= w_idx_end ? '0 : r_idx + 1'b1;
            end
        end else if (i_m_ready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_go) begin
            if (!i_cmd.tick) begin
                r_kind   <= KIND_VERDICT;
                r_last   <= 1'b1;
                r_mask   <= i_cmd.mask;
                r_count  <= i_cmd.count;
                r_accept <= i_cmd.accept;
                r_rch    <= '0;
                r_sum    <= '0;
                r_evc    <= '0;
            end else begin
                r_kind   <= KIND_REPORT;
                r_last   <= w_idx_end;
                r_mask   <= '0;
                r_count  <= '0;
                r_accept <= 1'b0;
                r_rch    <= r_idx;
                r_sum    <= r_total[r_idx];
                r_evc    <= r_evcnt[r_idx];
            end
        end
    end

    assign o_m_valid = r_m_valid;
    assign o_m_kind  = r_kind;
    assign o_m_last  = r_last;
    assign o_m_data  = {(OUT_TDATA_W - OUT_USED)'(0), r_evc, r_sum, r_rch,
                        r_accept, r_count, r_mask};

endmodule

`default_nettype wire

// ===== test/tb_event_trigger_and_pulse_height_unit.sv =====
// testbench for event_trigger_and_pulse_height_unit: directed table, then random events
// under several threshold settings and pacings; needs etpu_pkg and the unit rtl
`timescale 1ns / 1ps

module tb_event_trigger_and_pulse_height_unit;
    import etpu_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int PHASES         = 6;
    localparam int WORDS_PER_PHASE = 35;

    // mode code the block ignores
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    typedef enum int {PACE_NONE, PACE_FULL, PACE_SPARSE} t_pace;

    typedef struct packed {
        logic              kind;
        logic [NUM_CH-1:0] mask;
        logic [CNT_W-1:0]  hits;
        logic              accept;
        logic [CH_W-1:0]   rch;
        logic [SUM_W-1:0]  sum;
        logic [EVC_W-1:0]  evc;
        logic              last;
    } t_word;

    typedef struct packed {
        logic [1:0]        mode;
        logic [1:0]        ch;
        logic [15:0]       smp;
        logic              typed;
        logic [NUM_CH-1:0] mask;
        logic [CNT_W-1:0]  hits;
        logic              accept;
    } t_row;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_AW-1:0]      i_cfg_addr = '0;
    logic [CFG_DW-1:0]      i_cfg_data = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;   // sample[15:0]
    logic [IN_TUSER_W-1:0]  s_axis_tuser = '0;   // mode[1:0], channel[3:2]
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // trigger_mask[3:0], trigger_count[6:4], accept[7], report_channel[9:8],
    // height_sum[41:10], event_count[57:42]
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [0:0]             m_axis_tuser;        // kind[0]
    logic                   m_axis_tlast;

    event_trigger_and_pulse_height_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // block state as the testbench sees it
    logic signed [15:0] thr [NUM_CH];
    logic [CNT_W-1:0]   coinc;
    logic signed [15:0] pk_hi [NUM_CH];
    logic signed [15:0] pk_lo [NUM_CH];
    logic [NUM_CH-1:0]  trig;
    logic [SUM_W-1:0]   hsum [NUM_CH];
    logic [EVC_W-1:0]   hcnt [NUM_CH];

    t_word due_words [$];
    int    mismatches = 0;
    int    quiet_cycles = 0;
    t_pace tx_pace = PACE_FULL;
    t_pace rx_pace = PACE_FULL;

    t_row script [16] = '{
        // right after reset: zero reports, then an empty event
        '{MODE_TICK,   2'd2, 16'h1234, 1'b1, 4'b0000, 3'd0, 1'b0},
        '{MODE_EOE,    2'd3, 16'hFFFF, 1'b1, 4'b0000, 3'd0, 1'b0},
        '{MODE_SAMPLE, 2'd0, 16'h7FFF, 1'b0, 4'b0000, 3'd0, 1'b0},
        '{MODE_SAMPLE, 2'd0, 16'h8000, 1'b0, 4'b0000, 3'd0, 1'b0},  // negated needs 17 bits
        '{MODE_SAMPLE, 2'd1, 16'hFF9B, 1'b0, 4'b0000, 3'd0, 1'b0},  // -101, just over
        '{MODE_SAMPLE, 2'd2, 16'hFF9C, 1'b0, 4'b0000, 3'd0, 1'b0},  // -100, at level
        '{MODE_SAMPLE, 2'd3, 16'h0000, 1'b0, 4'b0000, 3'd0, 1'b0},
        '{MODE_EOE,    2'd0, 16'h0000, 1'b1, 4'b1100, 3'd2, 1'b1},
        // samples just past or right at the starting bounds
        '{MODE_SAMPLE, 2'd1, 16'd8200,  1'b0, 4'b0000, 3'd0, 1'b0},
        '{MODE_SAMPLE, 2'd2, -16'sd8200, 1'b0, 4'b0000, 3'd0, 1'b0},
        '{MODE_SAMPLE, 2'd3, -16'sd8100, 1'b0, 4'b0000, 3'd0, 1'b0},
        '{MODE_EOE,    2'd1, 16'h5A5A, 1'b0, 4'b0000, 3'd0, 1'b0},
        '{MODE_TICK,   2'd0, 16'h0000, 1'b0, 4'b0000, 3'd0, 1'b0},
        '{MODE_UNUSED, 2'd3, 16'hFFFF, 1'b0, 4'b0000, 3'd0, 1'b0},
        '{MODE_EOE,    2'd2, 16'hA5A5, 1'b1, 4'b0000, 3'd0, 1'b0},
        '{MODE_TICK,   2'd1, 16'h8001, 1'b1, 4'b0000, 3'd0, 1'b0}
    };

    task automatic flag_mismatch(input string what);
        $display("%0t mismatch: %s", $time, what);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            flag_mismatch($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    function automatic int draw_wait(input t_pace pace);
        case (pace)
            PACE_FULL:   return $urandom_range(0, 18);
            PACE_SPARSE: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 18) : 0;
            default:     return 0;
        endcase
    endfunction

    task automatic rearm_peaks();
        for (int i = 0; i < NUM_CH; i++) begin
            pk_hi[i] = START_MAX;
            pk_lo[i] = START_MIN;
        end
        trig = '0;
    endtask

    task automatic reset_unit_state();
        for (int i = 0; i < NUM_CH; i++) begin
            thr[i]  = THR_RESET;
            hsum[i] = '0;
            hcnt[i] = '0;
        end
        coinc = MIN_C_RESET;
        rearm_peaks();
    endtask

    // update the tracked state for one taken word and queue the words it owes
    task automatic process_event_word(input logic [1:0] mode, input logic [1:0] ch,
                                      input logic [15:0] smp, input bit typed,
                                      input t_word typed_w);
        logic signed [16:0] neg;
        logic signed [16:0] lvl;
        logic [32:0]        total;
        logic [CNT_W-1:0]   hits;
        int                 span;
        t_word              w;
        case (mode)
            MODE_SAMPLE: begin
                if ($signed(smp) > pk_hi[ch]) pk_hi[ch] = smp;
                if ($signed(smp) < pk_lo[ch]) pk_lo[ch] = smp;
                neg = -$signed({smp[15], smp});
                lvl = {thr[ch][15], thr[ch]};
                if (neg > lvl) trig[NUM_CH-1-ch] = 1'b1;
            end
            MODE_EOE: begin
                hits = '0;
                for (int i = 0; i < NUM_CH; i++) begin
                    hits += trig[i];
                    if (pk_hi[i] > pk_lo[i]) begin
                        span  = int'(pk_hi[i]) - int'(pk_lo[i]);
                        total = {1'b0, hsum[i]} + 33'(span);
                        hsum[i] = total[32] ? '1 : total[31:0];
                        if (hcnt[i] != '1) hcnt[i]++;
                    end
                end
                w = '0;
                w.kind   = KIND_VERDICT;
                w.mask   = trig;
                w.hits   = hits;
                w.accept = (hits >= coinc);
                w.last   = 1'b1;
                due_words.push_back(typed ? typed_w : w);
                rearm_peaks();
            end
            MODE_TICK: begin
                for (int i = 0; i < NUM_CH; i++) begin
                    w = '0;
                    w.kind = KIND_REPORT;
                    w.rch  = CH_W'(i);
                    w.sum  = typed ? '0 : hsum[i];
                    w.evc  = typed ? '0 : hcnt[i];
                    w.last = (i == NUM_CH - 1);
                    due_words.push_back(w);
                    hsum[i] = '0;
                    hcnt[i] = '0;
                end
            end
            default: ;
        endcase
    endtask

    task automatic send_word(input logic [1:0] mode, input logic [1:0] ch,
                             input logic [15:0] smp, input bit typed = 1'b0,
                             input t_word typed_w = '0);
        int gap;
        gap = draw_wait(tx_pace);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= {ch, mode};
        s_axis_tdata  <= smp;
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        process_event_word(mode, ch, smp, typed, typed_w);
    endtask

    function automatic logic [15:0] pick_sample(input logic [1:0] ch);
        case ($urandom_range(0, 7))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return -thr[ch];            // right at the trigger level
            3:       return -thr[ch] - 16'd1;    // one past it
            4, 5:    return 16'($urandom_range(0, 18000)) - 16'd9000;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_samples(input int n);
        logic [1:0] ch;
        for (int k = 0; k < n; k++) begin
            ch = 2'($urandom_range(0, 3));
            send_word(MODE_SAMPLE, ch, pick_sample(ch));
        end
    endtask

    // stop sending, let every owed word drain, then give the block time to go quiet
    task automatic wait_for_idle();
        s_axis_tvalid <= 1'b0;
        while (due_words.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [CFG_DW-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        if (idx <= REG_THR3)
            thr[idx[1:0]] = $signed(val);
        else if (idx == REG_MIN_COINC)
            coinc = val[CNT_W-1:0];
    endtask

    task automatic apply_setting(input int phase);
        logic [15:0]      lvl;
        logic [CNT_W-1:0] need;
        for (int c = 0; c < NUM_CH; c++) begin
            case (phase)
                0:       lvl = 16'h7FFF;
                1:       lvl = 16'h8000;
                2:       lvl = 16'($urandom_range(0, 6000)) - 16'd3000;
                3:       lvl = (c == 0) ? 16'h7FFF : (c == 1) ? 16'h8000 : 16'(c - 3);
                4:       lvl = 16'($urandom);
                default: lvl = 16'd100;
            endcase
            write_reg(REG_THR0 + CFG_AW'(c), lvl);
        end
        case (phase)
            0:       need = 3'd0;
            1:       need = 3'd4;
            2:       need = 3'($urandom_range(1, 3));
            3:       need = 3'd7;    // more than the channel count
            4:       need = 3'($urandom_range(0, 4));
            default: need = 3'd2;
        endcase
        write_reg(REG_MIN_COINC, CFG_DW'(need));
        // unmapped index, must change nothing
        write_reg(REG_MIN_COINC + CFG_AW'($urandom_range(1, 3)), 16'($urandom));
        i_cfg_we <= 1'b0;
    endtask

    always @(posedge i_clk) begin : result_monitor
        t_word w;
        if (i_rst_n && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) begin
            if (due_words.size() == 0) begin
                flag_mismatch("result word with nothing owed");
            end else begin
                w = due_words.pop_front();
                check_field("kind", m_axis_tuser[0], w.kind);
                check_field("trigger_mask", m_axis_tdata[OFF_MASK +: NUM_CH], w.mask);
                check_field("trigger_count", m_axis_tdata[OFF_COUNT +: CNT_W], w.hits);
                check_field("accept", m_axis_tdata[OFF_ACC], w.accept);
                check_field("report_channel", m_axis_tdata[OFF_RCH +: CH_W], w.rch);
                check_field("height_sum", m_axis_tdata[OFF_SUM +: SUM_W], w.sum);
                check_field("event_count", m_axis_tdata[OFF_EVC +: EVC_W], w.evc);
                check_field("last", m_axis_tlast, w.last);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid === 1'b1 && s_axis_tready === 1'b1) ||
            (m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // receiver: random stall before each word, sometimes none
    initial begin : receiver
        int stall;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            stall = draw_wait(rx_pace);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (m_axis_tvalid !== 1'b1);
        end
    end

    initial begin : stimulus
        t_word w;
        int    sent;
        int    n;
        reset_unit_state();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (script[k]) begin
            w = '0;
            w.kind   = KIND_VERDICT;
            w.mask   = script[k].mask;
            w.hits   = script[k].hits;
            w.accept = script[k].accept;
            w.last   = 1'b1;
            send_word(script[k].mode, script[k].ch, script[k].smp, script[k].typed, w);
        end

        for (int phase = 0; phase < PHASES; phase++) begin
            wait_for_idle();
            apply_setting(phase);
            case (phase)
                0: begin tx_pace = PACE_FULL; rx_pace = PACE_FULL; end
                1: begin tx_pace = PACE_NONE; rx_pace = PACE_FULL; end
                2: begin tx_pace = PACE_FULL; rx_pace = PACE_NONE; end
                default: begin
                    tx_pace = t_pace'($urandom_range(0, 2));
                    rx_pace = t_pace'($urandom_range(0, 2));
                end
            endcase
            sent = 0;
            while (sent < WORDS_PER_PHASE) begin
                case ($urandom_range(0, 19))
                    0: begin
                        send_word(MODE_TICK, 2'($urandom), 16'($urandom));
                        sent++;
                    end
                    1: send_word(MODE_UNUSED, 2'($urandom), 16'($urandom));
                    2: begin
                        // samples with no end of event; they fold into the next one
                        n = $urandom_range(1, 3);
                        send_samples(n);
                        sent += n;
                    end
                    default: begin
                        n = $urandom_range(1, 8);
                        send_samples(n);
                        send_word(MODE_EOE, 2'($urandom), 16'($urandom));
                        sent += n + 1;
                    end
                endcase
            end
        end

        // sparse sender against a busy receiver, ending on a report
        tx_pace = PACE_SPARSE;
        rx_pace = PACE_FULL;
        send_word(MODE_TICK, 2'd3, 16'hFFFF);
        send_samples(4);
        send_word(MODE_EOE, 2'd0, 16'h0000);
        send_word(MODE_TICK, 2'd1, 16'h0001);

        wait_for_idle();
        repeat (12) @(posedge i_clk);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/etpu_pkg.sv
hw/rtl/etpu_front.sv
hw/rtl/etpu_queue.sv
hw/rtl/etpu_back.sv
hw/rtl/event_trigger_and_pulse_height_unit.sv
test/tb_event_trigger_and_pulse_height_unit.sv
